@@ hdl/hkre_pkg.sv @@
// hkre_pkg: shared types, constants and the key usage decoder
// for the hid keyboard report block; no dependencies
`timescale 1ns / 1ps

package hkre_pkg;

  localparam int KEY_SLOTS_DEF = 6;
  localparam int REPORT_BYTES  = 8;
  localparam int KEY_BYTES     = 7;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 2'd2;

  localparam logic [15:0] DELAY_RESET    = 16'd500;
  localparam logic [15:0] INTERVAL_RESET = 16'd50;

  localparam logic       KIND_TICK  = 1'b1;
  localparam logic [3:0] MIN_COUNT  = 4'd2;
  localparam logic [7:0] SHIFT_MASK = 8'h02;
  localparam logic [7:0] MOD_FIRST  = 8'hE0;
  localparam logic [7:0] MOD_LAST   = 8'hE7;

  localparam logic [7:0] U_A      = 8'h04;
  localparam logic [7:0] U_Z      = 8'h1D;
  localparam logic [7:0] U_1      = 8'h1E;
  localparam logic [7:0] U_9      = 8'h26;
  localparam logic [7:0] U_ENTER  = 8'h28;
  localparam logic [7:0] U_ESC    = 8'h29;
  localparam logic [7:0] U_BKSP   = 8'h2A;
  localparam logic [7:0] U_TAB    = 8'h2B;
  localparam logic [7:0] U_CAPS   = 8'h39;
  localparam logic [7:0] U_HOME   = 8'h4A;
  localparam logic [7:0] U_DELETE = 8'h4C;
  localparam logic [7:0] U_END    = 8'h4D;
  localparam logic [7:0] U_RIGHT  = 8'h4F;
  localparam logic [7:0] U_LEFT   = 8'h50;
  localparam logic [7:0] U_DOWN   = 8'h51;
  localparam logic [7:0] U_UP     = 8'h52;

  localparam logic [3:0] ACT_CHAR  = 4'd0;
  localparam logic [3:0] ACT_ENTER = 4'd1;
  localparam logic [3:0] ACT_ESC   = 4'd2;
  localparam logic [3:0] ACT_BKSP  = 4'd3;
  localparam logic [3:0] ACT_DEL   = 4'd4;
  localparam logic [3:0] ACT_LEFT  = 4'd5;
  localparam logic [3:0] ACT_RIGHT = 4'd6;
  localparam logic [3:0] ACT_UP    = 4'd7;
  localparam logic [3:0] ACT_DOWN  = 4'd8;
  localparam logic [3:0] ACT_HOME  = 4'd9;
  localparam logic [3:0] ACT_END   = 4'd10;
  localparam logic [3:0] ACT_CAPS  = 4'd11;

  localparam logic [1:0] DK_NONE   = 2'd0;
  localparam logic [1:0] DK_ONCE   = 2'd1;
  localparam logic [1:0] DK_REPEAT = 2'd2;

  typedef struct packed {
    logic        kind;
    logic [7:0]  report_modifiers;
    logic [7:0]  key_byte_1;
    logic [7:0]  key_byte_2;
    logic [7:0]  key_byte_3;
    logic [7:0]  key_byte_4;
    logic [7:0]  key_byte_5;
    logic [7:0]  key_byte_6;
    logic [7:0]  key_byte_7;
    logic [3:0]  byte_count;
    logic [31:0] time_ms;
  } in_item_t;

  typedef struct packed {
    logic [7:0] key_code;
    logic [3:0] action;
    logic [6:0] char_code;
    logic [7:0] modifiers_in_effect;
    logic       caps_lock_on;
    logic       is_repeat;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] action;
    logic [6:0] ch;
  } dec_t;

  typedef struct packed {
    logic push;
    logic finish;
  } oseq_ctl_t;

  typedef struct packed {
    logic can_push;
    logic finish_done;
  } oseq_sts_t;

  function automatic logic [6:0] shifted_digit(input logic [7:0] u);
    logic [6:0] c;
    unique case (u)
      8'h1E:   c = 7'h21;
      8'h1F:   c = 7'h40;
      8'h20:   c = 7'h23;
      8'h21:   c = 7'h24;
      8'h22:   c = 7'h25;
      8'h23:   c = 7'h5E;
      8'h24:   c = 7'h26;
      8'h25:   c = 7'h2A;
      8'h26:   c = 7'h28;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  function automatic logic [6:0] usage_char(input logic [7:0] u, input logic sh);
    logic [6:0] c;
    if (u >= U_A && u <= U_Z) begin
      c = (sh ? 7'h41 : 7'h61) + 7'(u - U_A);
    end else if (u >= U_1 && u <= U_9) begin
      c = sh ? shifted_digit(u) : 7'h31 + 7'(u - U_1);
    end else begin
      unique case (u)
        8'h27:   c = sh ? 7'h29 : 7'h30;
        8'h2C:   c = 7'h20;
        8'h2D:   c = sh ? 7'h5F : 7'h2D;
        8'h2E:   c = sh ? 7'h2B : 7'h3D;
        8'h2F:   c = sh ? 7'h7B : 7'h5B;
        8'h30:   c = sh ? 7'h7D : 7'h5D;
        8'h31:   c = sh ? 7'h7C : 7'h5C;
        8'h33:   c = sh ? 7'h3A : 7'h3B;
        8'h34:   c = sh ? 7'h22 : 7'h27;
        8'h35:   c = sh ? 7'h7E : 7'h60;
        8'h36:   c = sh ? 7'h3C : 7'h2C;
        8'h37:   c = sh ? 7'h3E : 7'h2E;
        8'h38:   c = sh ? 7'h3F : 7'h2F;
        default: c = 7'h00;
      endcase
    end
    return c;
  endfunction

  function automatic dec_t key_decode(input logic [7:0] u, input logic sh);
    dec_t d;
    d.kind   = DK_NONE;
    d.action = ACT_CHAR;
    d.ch     = 7'h00;
    unique case (u)
      U_ENTER:  begin d.kind = DK_REPEAT; d.action = ACT_ENTER; end
      U_ESC:    begin d.kind = DK_ONCE;   d.action = ACT_ESC;   end
      U_BKSP:   begin d.kind = DK_REPEAT; d.action = ACT_BKSP;  end
      U_TAB:    begin d.kind = DK_REPEAT; d.ch = 7'h09;         end
      U_DELETE: begin d.kind = DK_REPEAT; d.action = ACT_DEL;   end
      U_RIGHT:  begin d.kind = DK_REPEAT; d.action = ACT_RIGHT; end
      U_LEFT:   begin d.kind = DK_REPEAT; d.action = ACT_LEFT;  end
      U_DOWN:   begin d.kind = DK_REPEAT; d.action = ACT_DOWN;  end
      U_UP:     begin d.kind = DK_REPEAT; d.action = ACT_UP;    end
      U_HOME:   begin d.kind = DK_ONCE;   d.action = ACT_HOME;  end
      U_END:    begin d.kind = DK_ONCE;   d.action = ACT_END;   end
      U_CAPS:   begin d.kind = DK_ONCE;   d.action = ACT_CAPS;  end
      default: begin
        d.ch   = usage_char(u, sh);
        d.kind = (d.ch != 7'h00) ? DK_REPEAT : DK_NONE;
      end
    endcase
    return d;
  endfunction

endpackage

@@ hdl/hkre_if.sv @@
// hkre_report_if / hkre_event_if: valid-ready channels for reports and key events
// depends on hkre_pkg
`timescale 1ns / 1ps

interface hkre_report_if;
  logic               valid;
  logic               ready;
  hkre_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hkre_event_if;
  logic                valid;
  logic                ready;
  hkre_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/hkre_sub_unit.sv @@
// hkre_sub_unit: shared 32-bit subtractor with borrow, used for hold-time math
// depends on nothing
`timescale 1ns / 1ps

module hkre_sub_unit (
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] diff,
  output logic        borrow
);

  logic [32:0] wide;

  assign wide   = {1'b0, a} - {1'b0, b};
  assign diff   = wide[31:0];
  assign borrow = wide[32];

endmodule

@@ hdl/hkre_out_stage.sv @@
// hkre_out_stage: one-deep pending buffer plus output register; marks the last event
// depends on hkre_pkg, hkre_if
`timescale 1ns / 1ps

module hkre_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  hkre_pkg::oseq_ctl_t ctl,
  input  hkre_pkg::out_item_t push_item,
  output hkre_pkg::oseq_sts_t sts,
  hkre_event_if.source        ev
);

  hkre_pkg::out_item_t pend;
  logic                pend_valid;
  hkre_pkg::out_item_t pend_mid;
  hkre_pkg::out_item_t pend_fin;
  hkre_pkg::out_item_t out_data;
  logic                out_valid;
  logic                out_free;

  assign out_free        = !out_valid || ev.ready;
  assign sts.can_push    = !pend_valid || out_free;
  assign sts.finish_done = !pend_valid || out_free;
  assign ev.valid        = out_valid;
  assign ev.data         = out_data;

  // pending transaction with the last flag cleared or set
  always_comb begin
    pend_mid      = pend;
    pend_mid.last = 1'b0;
    pend_fin      = pend;
    pend_fin.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_free) begin
        if (ctl.push && pend_valid) begin
          out_data  <= pend_mid;
          out_valid <= 1'b1;
        end else if (ctl.finish && pend_valid) begin
          out_data  <= pend_fin;
          out_valid <= 1'b1;
        end else begin
          out_valid <= 1'b0;
        end
      end
      if (ctl.push && sts.can_push) begin
        pend       <= push_item;
        pend_valid <= 1'b1;
      end else if (ctl.finish && pend_valid && out_free) begin
        pend_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/hid_keyboard_report_to_key_events_core.sv @@
// report: accept, a release scan over the key bytes, a press scan over them, then flush
//   (one key byte per cycle in each scan; the press scan and the flush hold while the output stalls)
// tick: accept, then each slot in turn through the shared subtractor (since, delay,
//   interval, fire), then flush; one item in flight
// reset: synchronous; frees all slots, clears caps lock and modifiers,
//   disables the block and loads delay 500 ms and interval 50 ms
`timescale 1ns / 1ps

module hid_keyboard_report_to_key_events_core #(
  parameter int KEY_SLOTS = hkre_pkg::KEY_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [hkre_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hkre_pkg::CFG_DATA_W-1:0] cfg_data,
  hkre_report_if.sink                     report_ch,
  hkre_event_if.source                    key_event_ch
);

  localparam int SW  = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int NKW = $clog2(KEY_SLOTS + 1);
  localparam logic [SW-1:0]  LAST_SLOT  = SW'(KEY_SLOTS - 1);
  localparam logic [NKW-1:0] SLOT_COUNT = NKW'(KEY_SLOTS);
  localparam logic [2:0]     FIRST_BYTE = 3'd1;
  localparam logic [2:0]     LAST_BYTE  = 3'(hkre_pkg::KEY_BYTES);

  typedef enum logic [2:0] {
    ST_IDLE, ST_RELEASE, ST_PRESS, ST_T_SINCE, ST_T_DELAY, ST_T_INTV, ST_T_FIRE, ST_FLUSH
  } state_t;

  state_t             state;
  logic               enabled;
  logic [15:0]        delay;
  logic [15:0]        interval;
  hkre_pkg::in_item_t item;
  logic [2:0]         bidx;
  logic [NKW-1:0]     nk;
  logic [KEY_SLOTS-1:0] held_mask;
  logic [SW-1:0]      sidx;
  logic [31:0]        acc;
  logic [7:0]         slot_key  [KEY_SLOTS];
  logic [31:0]        slot_time [KEY_SLOTS];
  logic [7:0]         held_mods;
  logic               caps;

  logic [7:0]           cur_byte;
  logic [3:0]           eff_count;
  logic                 byte_ok;
  logic [KEY_SLOTS-1:0] match;
  logic [KEY_SLOTS-1:0] free;
  logic                 present;
  logic                 any_free;
  logic [SW-1:0]        free_idx;
  hkre_pkg::dec_t       dec_press;
  hkre_pkg::dec_t       dec_tick;
  logic [7:0]           tkey;
  logic [31:0]          ttime;
  logic                 press_fire;
  logic                 tick_fire;
  logic                 caps_toggle;
  logic                 stall;
  logic [31:0]          sub_a;
  logic [31:0]          sub_b;
  logic [31:0]          sub_diff;
  logic                 sub_borrow;
  hkre_pkg::oseq_ctl_t  ctl;
  hkre_pkg::oseq_sts_t  sts;
  hkre_pkg::out_item_t  push_item;

  // key byte under the scan pointer
  always_comb begin
    unique case (bidx)
      3'd1:    cur_byte = item.key_byte_1;
      3'd2:    cur_byte = item.key_byte_2;
      3'd3:    cur_byte = item.key_byte_3;
      3'd4:    cur_byte = item.key_byte_4;
      3'd5:    cur_byte = item.key_byte_5;
      3'd6:    cur_byte = item.key_byte_6;
      3'd7:    cur_byte = item.key_byte_7;
      default: cur_byte = 8'h00;
    endcase
  end

  assign eff_count = (item.byte_count > 4'(hkre_pkg::REPORT_BYTES)) ?
                     4'(hkre_pkg::REPORT_BYTES) : item.byte_count;
  assign byte_ok = ({1'b0, bidx} < eff_count) && (nk < SLOT_COUNT) && (cur_byte != 8'h00) &&
                   !(cur_byte >= hkre_pkg::MOD_FIRST && cur_byte <= hkre_pkg::MOD_LAST);

  always_comb begin
    free_idx = '0;
    for (int s = 0; s < KEY_SLOTS; s++) begin
      match[s] = (slot_key[s] == cur_byte);
      free[s]  = (slot_key[s] == 8'h00);
    end
    for (int s = KEY_SLOTS - 1; s >= 0; s--) begin
      if (free[s]) free_idx = SW'(s);
    end
  end

  assign present  = |match;
  assign any_free = |free;
  assign tkey     = slot_key[sidx];
  assign ttime    = slot_time[sidx];

  assign dec_press = hkre_pkg::key_decode(cur_byte,
                       ((item.report_modifiers & hkre_pkg::SHIFT_MASK) != 8'h00) || caps);
  assign dec_tick  = hkre_pkg::key_decode(tkey,
                       ((held_mods & hkre_pkg::SHIFT_MASK) != 8'h00) || caps);

  assign press_fire  = (state == ST_PRESS) && byte_ok && !present && any_free &&
                       (dec_press.kind != hkre_pkg::DK_NONE);
  assign tick_fire   = (state == ST_T_FIRE) && (dec_tick.kind != hkre_pkg::DK_NONE);
  assign caps_toggle = press_fire && (cur_byte == hkre_pkg::U_CAPS);
  assign ctl.push    = press_fire || tick_fire;
  assign ctl.finish  = (state == ST_FLUSH);
  assign stall       = ctl.push && !sts.can_push;

  always_comb begin
    if (state == ST_PRESS) begin
      push_item.key_code            = cur_byte;
      push_item.action              = dec_press.action;
      push_item.char_code           = dec_press.ch;
      push_item.modifiers_in_effect = item.report_modifiers;
      push_item.caps_lock_on        = caps ^ caps_toggle;
      push_item.is_repeat           = 1'b0;
    end else begin
      push_item.key_code            = tkey;
      push_item.action              = dec_tick.action;
      push_item.char_code           = dec_tick.ch;
      push_item.modifiers_in_effect = held_mods;
      push_item.caps_lock_on        = caps;
      push_item.is_repeat           = 1'b1;
    end
    push_item.last = 1'b0;
  end

  // operand select for the shared subtractor
  always_comb begin
    unique case (state)
      ST_T_SINCE: begin sub_a = item.time_ms; sub_b = ttime;           end
      ST_T_DELAY: begin sub_a = acc;          sub_b = {16'h0, delay};    end
      ST_T_INTV:  begin sub_a = acc;          sub_b = {16'h0, interval}; end
      default:    begin sub_a = item.time_ms; sub_b = {16'h0, delay};    end
    endcase
  end

  hkre_sub_unit u_sub (
    .a      (sub_a),
    .b      (sub_b),
    .diff   (sub_diff),
    .borrow (sub_borrow)
  );

  hkre_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .push_item (push_item),
    .sts       (sts),
    .ev        (key_event_ch)
  );

  assign report_ch.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      enabled   <= 1'b0;
      delay     <= hkre_pkg::DELAY_RESET;
      interval  <= hkre_pkg::INTERVAL_RESET;
      bidx      <= FIRST_BYTE;
      nk        <= '0;
      held_mask <= '0;
      sidx      <= '0;
      held_mods <= 8'h00;
      caps      <= 1'b0;
      for (int s = 0; s < KEY_SLOTS; s++) begin
        slot_key[s]  <= 8'h00;
        slot_time[s] <= 32'h0;
      end
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          hkre_pkg::REG_ENABLE:   enabled  <= cfg_data[0];
          hkre_pkg::REG_DELAY:    delay    <= cfg_data;
          hkre_pkg::REG_INTERVAL: interval <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (report_ch.valid) begin
            item      <= report_ch.data;
            bidx      <= FIRST_BYTE;
            nk        <= '0;
            held_mask <= '0;
            sidx      <= '0;
            if (enabled) begin
              if (report_ch.data.kind == hkre_pkg::KIND_TICK) begin
                state <= ST_T_SINCE;
              end else if (report_ch.data.byte_count >= hkre_pkg::MIN_COUNT) begin
                state <= ST_RELEASE;
              end
            end
          end
        end
        ST_RELEASE: begin
          if (byte_ok) begin
            held_mask <= held_mask | match;
            nk        <= nk + 1'b1;
          end
          if (bidx == LAST_BYTE) begin
            // free slots whose key is gone from the report
            for (int s = 0; s < KEY_SLOTS; s++) begin
              if (!(held_mask[s] || (byte_ok && match[s]))) slot_key[s] <= 8'h00;
            end
            bidx  <= FIRST_BYTE;
            nk    <= '0;
            state <= ST_PRESS;
          end else begin
            bidx <= bidx + 1'b1;
          end
        end
        ST_PRESS: begin
          if (!stall) begin
            if (byte_ok) nk <= nk + 1'b1;
            if (press_fire) begin
              if (caps_toggle) caps <= ~caps;
              if (dec_press.kind == hkre_pkg::DK_REPEAT) begin
                slot_key[free_idx]  <= cur_byte;
                slot_time[free_idx] <= item.time_ms;
              end
            end
            if (bidx == LAST_BYTE) begin
              held_mods <= item.report_modifiers;
              state     <= ST_FLUSH;
            end else begin
              bidx <= bidx + 1'b1;
            end
          end
        end
        ST_T_SINCE: begin
          if (tkey == 8'h00) begin
            sidx  <= (sidx == LAST_SLOT) ? '0 : sidx + 1'b1;
            state <= (sidx == LAST_SLOT) ? ST_FLUSH : ST_T_SINCE;
          end else begin
            acc   <= sub_diff;
            state <= ST_T_DELAY;
          end
        end
        ST_T_DELAY: begin
          if (sub_borrow) begin
            sidx  <= (sidx == LAST_SLOT) ? '0 : sidx + 1'b1;
            state <= (sidx == LAST_SLOT) ? ST_FLUSH : ST_T_SINCE;
          end else begin
            acc   <= sub_diff;
            state <= ST_T_INTV;
          end
        end
        ST_T_INTV: begin
          if (sub_borrow) begin
            sidx  <= (sidx == LAST_SLOT) ? '0 : sidx + 1'b1;
            state <= (sidx == LAST_SLOT) ? ST_FLUSH : ST_T_SINCE;
          end else begin
            state <= ST_T_FIRE;
          end
        end
        ST_T_FIRE: begin
          if (!stall) begin
            // restart the interval: time base becomes now minus delay
            slot_time[sidx] <= sub_diff;
            sidx  <= (sidx == LAST_SLOT) ? '0 : sidx + 1'b1;
            state <= (sidx == LAST_SLOT) ? ST_FLUSH : ST_T_SINCE;
          end
        end
        ST_FLUSH: begin
          if (sts.finish_done) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/hkre_checker.sv @@
// hkre_checker: port-level assertions on the key event channel, bound to the core
// depends on hkre_pkg and hid_keyboard_report_to_key_events_core
`timescale 1ns / 1ps

module hkre_checker (
  input logic                clk,
  input logic                rst,
  input logic                ev_valid,
  input logic                ev_ready,
  input hkre_pkg::out_item_t ev_data
);

  // stalled transaction holds
  assert property (@(posedge clk) disable iff (rst)
    ev_valid && !ev_ready |=> ev_valid && $stable(ev_data))
    else $error("event changed while stalled");

  // nothing comes out right after reset
  assert property (@(posedge clk) rst |=> !ev_valid)
    else $error("event valid after reset");

  // only character events carry a character
  assert property (@(posedge clk) disable iff (rst)
    ev_valid |-> (ev_data.action == hkre_pkg::ACT_CHAR) || (ev_data.char_code == 7'h00))
    else $error("char code on non-char action");

  // repeat events come only from repeatable keys
  assert property (@(posedge clk) disable iff (rst)
    ev_valid && ev_data.is_repeat |->
      ev_data.action != hkre_pkg::ACT_ESC && ev_data.action != hkre_pkg::ACT_HOME &&
      ev_data.action != hkre_pkg::ACT_END && ev_data.action != hkre_pkg::ACT_CAPS)
    else $error("repeat of non-repeating key");

endmodule

bind hid_keyboard_report_to_key_events_core hkre_checker u_hkre_checker (
  .clk      (clk),
  .rst      (rst),
  .ev_valid (key_event_ch.valid),
  .ev_ready (key_event_ch.ready),
  .ev_data  (key_event_ch.data)
);
